// ===== sv/phlt_pkg.sv =====
// Package: widths, codes, state and command types for the peer liveness table.
package phlt_pkg;

  localparam int unsigned Peers    = 32;
  localparam int unsigned SlotW    = $clog2(Peers);
  localparam int unsigned CntW     = $clog2(Peers + 1);
  localparam int unsigned KeyW     = 48;
  localparam int unsigned TimeW    = 48;
  localparam int unsigned DueW     = 49;
  localparam int unsigned RegW     = 32;
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 104;

  typedef enum logic [2:0] {
    FnWatch    = 3'd0,
    FnUnwatch  = 3'd1,
    FnIsWatch  = 3'd2,
    FnSent     = 3'd3,
    FnRecv     = 3'd4,
    FnTick     = 3'd5,
    FnDeadline = 3'd6,
    FnNone     = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    KindAck    = 2'd0,
    KindDue    = 2'd1,
    KindSilent = 2'd2,
    KindAnswer = 2'd3
  } kind_e;

  localparam logic RegInterval = 1'b0;
  localparam logic RegTimeout  = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StEval,
    StEmit,
    StDone
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture input word, clear scan state
    logic rd;        // issue read of slot at scan index
    logic eval;      // evaluate read data for current slot
    logic adv;       // unused by the datapath; rd advances the scan index
    logic fin;       // apply final update for non-tick function
    logic emit_slot; // present per-slot tick result
    logic emit_fin;  // present final result
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_end;  // scan index is past the last slot
    logic report;    // current slot gives a tick result
    logic is_tick;
  } sts_t;

endpackage

// ===== sv/phlt_ram.sv =====
// Generic RAM with one write port and one registered read port.
module phlt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== sv/phlt_ctrl.sv =====
// Controller: sequences the slot scan and result handshake.
module phlt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_fire_i,
  input  logic             out_busy_i,
  input  phlt_pkg::sts_t   sts_i,
  output phlt_pkg::cmd_t   cmd_o,
  output logic             idle_o
);
  phlt_pkg::state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      phlt_pkg::StIdle: if (in_fire_i) state_d = phlt_pkg::StRead;
      phlt_pkg::StRead: begin
        if (sts_i.scan_end) state_d = phlt_pkg::StDone;
        else state_d = phlt_pkg::StEval;
      end
      phlt_pkg::StEval: begin
        if (sts_i.is_tick && sts_i.report) state_d = phlt_pkg::StEmit;
        else state_d = phlt_pkg::StRead;
      end
      phlt_pkg::StEmit: if (!out_busy_i) state_d = phlt_pkg::StRead;
      phlt_pkg::StDone: if (!out_busy_i) state_d = phlt_pkg::StIdle;
      default: state_d = phlt_pkg::StIdle;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o = '0;
    idle_o = 1'b0;
    case (state_q)
      phlt_pkg::StIdle: begin
        idle_o = 1'b1;
        cmd_o.load = in_fire_i;
      end
      phlt_pkg::StRead: cmd_o.rd = !sts_i.scan_end;
      phlt_pkg::StEval: begin
        cmd_o.eval = 1'b1;
        cmd_o.adv = 1'b1;
      end
      phlt_pkg::StEmit: cmd_o.emit_slot = !out_busy_i;
      phlt_pkg::StDone: begin
        cmd_o.fin = !out_busy_i;
        cmd_o.emit_fin = !out_busy_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= phlt_pkg::StIdle;
    else state_q <= state_d;
  end
endmodule

// ===== sv/phlt_dp.sv =====
// Datapath: slot store, scan evaluation, deadline minimum and result register.
module phlt_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [phlt_pkg::RegW-1:0]         cfg_data_i,
  input  logic [phlt_pkg::InDataW-1:0]      in_data_i,
  input  phlt_pkg::cmd_t                    cmd_i,
  output phlt_pkg::sts_t                    sts_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [phlt_pkg::OutDataW-1:0]     out_data_o,
  output logic [1:0]                        out_user_o,
  output logic                              out_last_o
);
  localparam int unsigned RowW = phlt_pkg::KeyW + 2 * phlt_pkg::TimeW;

  logic [phlt_pkg::RegW-1:0]  hb_q, to_q;
  logic [2:0]                 func_q;
  logic [phlt_pkg::KeyW-1:0]  key_q;
  logic [phlt_pkg::TimeW-1:0] now_q;
  logic [phlt_pkg::CntW-1:0]  idx_q;
  logic [phlt_pkg::Peers-1:0] valid_q;
  logic                       hit_q, free_q;
  logic [phlt_pkg::SlotW-1:0] hit_slot_q, free_slot_q;
  logic [phlt_pkg::TimeW-1:0] hit_sent_q, hit_recv_q;
  logic                       have_q;
  logic [phlt_pkg::DueW-1:0]  best_q;
  logic [phlt_pkg::SlotW-1:0] cur_slot;
  logic [RowW-1:0]            rdata, wdata;
  logic [phlt_pkg::SlotW-1:0] waddr, raddr;
  logic                       we;
  logic [phlt_pkg::KeyW-1:0]  r_key;
  logic [phlt_pkg::TimeW-1:0] r_sent, r_recv;
  logic                       silent, due, cur_valid;
  logic [phlt_pkg::DueW-1:0]  due_a, due_b, due_m;
  logic [phlt_pkg::SlotW-1:0] eval_slot;
  phlt_pkg::kind_e            res_kind;
  logic [phlt_pkg::OutDataW-1:0] res_data;

  assign cur_slot  = idx_q[phlt_pkg::SlotW-1:0];
  assign eval_slot = cur_slot - phlt_pkg::SlotW'(1);
  assign {r_recv, r_sent, r_key} = rdata;
  assign cur_valid = valid_q[eval_slot];

  // Read the next slot on a scan step, otherwise keep rereading the slot under evaluation.
  assign raddr = cmd_i.rd ? cur_slot : eval_slot;

  // Evaluate the slot just read.
  assign silent = (now_q >= r_recv) &&
                  ((now_q - r_recv) >= phlt_pkg::TimeW'(to_q));
  assign due    = (now_q >= r_sent) &&
                  ((now_q - r_sent) >= phlt_pkg::TimeW'(hb_q));
  assign due_a  = phlt_pkg::DueW'(r_sent) + phlt_pkg::DueW'(hb_q);
  assign due_b  = phlt_pkg::DueW'(r_recv) + phlt_pkg::DueW'(to_q);
  assign due_m  = (due_a < due_b) ? due_a : due_b;

  assign sts_o.scan_end = (idx_q == phlt_pkg::CntW'(phlt_pkg::Peers));
  assign sts_o.report   = cur_valid && (silent || due);
  assign sts_o.is_tick  = (func_q == phlt_pkg::FnTick);

  // Slot writes: tick heartbeat update, or final update for watch/sent/received.
  always_comb begin
    we = 1'b0;
    waddr = hit_slot_q;
    wdata = {hit_recv_q, hit_sent_q, key_q};
    if (cmd_i.emit_slot && !silent) begin
      we = 1'b1;
      waddr = eval_slot;
      wdata = {r_recv, now_q, r_key};
    end else if (cmd_i.fin) begin
      case (func_q)
        phlt_pkg::FnWatch: begin
          we = hit_q || free_q;
          waddr = hit_q ? hit_slot_q : free_slot_q;
          wdata = {now_q, now_q, key_q};
        end
        phlt_pkg::FnSent: begin
          we = hit_q && (now_q > hit_sent_q);
          wdata = {hit_recv_q, now_q, key_q};
        end
        phlt_pkg::FnRecv: begin
          we = hit_q && (now_q > hit_recv_q);
          wdata = {now_q, hit_sent_q, key_q};
        end
        default: we = 1'b0;
      endcase
    end
  end

  phlt_ram #(.Width(RowW), .Depth(phlt_pkg::Peers)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_q <= phlt_pkg::RegW'(1000);
      to_q <= phlt_pkg::RegW'(3000);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == phlt_pkg::RegInterval) hb_q <= cfg_data_i;
      else to_q <= cfg_data_i;
    end
  end

  // Capture the input word and walk the slots.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= in_data_i[2:0];
      key_q  <= in_data_i[50:3];
      now_q  <= in_data_i[98:51];
      idx_q  <= '0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      have_q <= 1'b0;
      best_q <= '0;
    end else begin
      if (cmd_i.rd) idx_q <= idx_q + phlt_pkg::CntW'(1);
      if (cmd_i.eval) begin
        if (!cur_valid && !free_q) begin
          free_q <= 1'b1;
          free_slot_q <= eval_slot;
        end
        if (cur_valid && !hit_q && r_key == key_q) begin
          hit_q <= 1'b1;
          hit_slot_q <= eval_slot;
          hit_sent_q <= r_sent;
          hit_recv_q <= r_recv;
        end
        if (cur_valid && (!have_q || due_m < best_q)) begin
          have_q <= 1'b1;
          best_q <= due_m;
        end
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= '0;
    else if (cmd_i.emit_slot && silent) valid_q[eval_slot] <= 1'b0;
    else if (cmd_i.fin) begin
      if (func_q == phlt_pkg::FnWatch && !hit_q && free_q) valid_q[free_slot_q] <= 1'b1;
      if (func_q == phlt_pkg::FnUnwatch && hit_q) valid_q[hit_slot_q] <= 1'b0;
    end
  end

  // Build the final result word: key[47:0], found[48], deadline[97:49], refused[98].
  always_comb begin
    res_kind = phlt_pkg::KindAck;
    res_data = {56'd0, key_q};
    case (func_q)
      phlt_pkg::FnWatch: res_data = {5'd0, !hit_q && !free_q, 49'd0, 1'b0, key_q};
      phlt_pkg::FnIsWatch: begin
        res_kind = phlt_pkg::KindAnswer;
        res_data = {55'd0, hit_q, key_q};
      end
      phlt_pkg::FnTick, phlt_pkg::FnNone: res_data = '0;
      phlt_pkg::FnDeadline: begin
        res_kind = phlt_pkg::KindAnswer;
        res_data = {6'd0, have_q ? best_q : 49'd0, have_q, 48'd0};
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (cmd_i.emit_slot || cmd_i.emit_fin) out_valid_o <= 1'b1;
    else if (out_ready_i) out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_slot) begin
      out_user_o <= silent ? phlt_pkg::KindSilent : phlt_pkg::KindDue;
      out_data_o <= {56'd0, r_key};
      out_last_o <= 1'b0;
    end else if (cmd_i.emit_fin) begin
      out_user_o <= res_kind;
      out_data_o <= res_data;
      out_last_o <= 1'b1;
    end
  end
  logic unused;
  assign unused = |in_data_i[103:99];
endmodule

// ===== sv/peer_heartbeat_liveness_table_top.sv =====
// Top level: peer heartbeat liveness table.
//  channel   dir  handshake        payload
//  s_axis    in   tvalid/tready    tdata: func, peer_key, now
//  m_axis    out  tvalid/tready    tdata: peer_key_res, found, deadline, refused; tuser kind; tlast
//  cfg       in   cfg_we_i         index 0 interval, 1 timeout
// Every item walks all slots through the RAM's single read port, with a read and an
// evaluate step per slot and an emit step per tick result, plus output stalls.
// Reset clears valid bits at once; slot contents need no clearing.
// A result waits in the output register; the walk holds at the next result until it is taken.
module peer_heartbeat_liveness_table_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [31:0]   cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [103:0]  s_axis_tdata,   // func[2:0], peer_key[50:3], now[98:51]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [103:0]  m_axis_tdata,   // peer_key_res[47:0], found, deadline, refused
  output logic [1:0]    m_axis_tuser,   // kind
  output logic          m_axis_tlast
);
  phlt_pkg::cmd_t cmd;
  phlt_pkg::sts_t sts;
  logic idle, fire, busy;

  assign s_axis_tready = idle;
  assign fire = s_axis_tvalid && idle;
  assign busy = m_axis_tvalid && !m_axis_tready;

  phlt_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_fire_i(fire), .out_busy_i(busy),
    .sts_i(sts), .cmd_o(cmd), .idle_o(idle)
  );

  phlt_dp u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_data_i(s_axis_tdata), .cmd_i(cmd), .sts_o(sts),
    .out_ready_i(m_axis_tready), .out_valid_o(m_axis_tvalid),
    .out_data_o(m_axis_tdata), .out_user_o(m_axis_tuser), .out_last_o(m_axis_tlast)
  );
endmodule

// ===== sv/phlt_checker.sv =====
// Checker: port-level properties of the liveness table, bound to the top level.
module phlt_port_props (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser,
  input logic         m_axis_tlast
);
  // A refused watch answers with a final acknowledgement.
  a_refused_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[98]) |->
      (m_axis_tuser == phlt_pkg::KindAck && m_axis_tlast))
    else $error("refused result not a final acknowledgement");
  // Accepting a word drops ready next cycle.
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("ready held");
  // Per-slot results are never last.
  a_slot_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == phlt_pkg::KindDue ||
                       m_axis_tuser == phlt_pkg::KindSilent)) |-> !m_axis_tlast)
    else $error("slot result marked last");
  // Stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed under stall");
endmodule

bind peer_heartbeat_liveness_table_top phlt_port_props u_chk (.*);
